// ===== rtl/core/swd_hte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_hte_pkg
// Types and constants of the serial wire debug host transfer engine.
// ----------------------------------------------------------------------------
package swd_hte_pkg;

   localparam int PhaseWidth = 4;
   localparam int CountWidth = 7;

   localparam logic [PhaseWidth-1:0] PH_IDLE   = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_ONES_A = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_SWITCH = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_ONES_B = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_ZEROS  = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_REQ    = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_ACK    = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_WDATA  = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_WPAR   = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_WIDLE  = 4'd9;
   localparam logic [PhaseWidth-1:0] PH_RDATA  = 4'd10;
   localparam logic [PhaseWidth-1:0] PH_RPAR   = 4'd11;
   localparam logic [PhaseWidth-1:0] PH_RIDLE  = 4'd12;
   localparam logic [PhaseWidth-1:0] PH_FAIL   = 4'd13;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_RESET = 2'd2;

   localparam logic [15:0] SWITCH_CODE = 16'he79e;
   localparam logic [2:0]  ACK_OK      = 3'b001;
   localparam logic [3:0]  RETRY_RESET = 4'd15;

   localparam logic [CountWidth-1:0] LEN_LINE   = 7'd64;
   localparam logic [CountWidth-1:0] LEN_SWITCH = 7'd16;
   localparam logic [CountWidth-1:0] LEN_REQ    = 7'd8;
   localparam logic [CountWidth-1:0] LEN_ACK    = 7'd3;
   localparam logic [CountWidth-1:0] LEN_WORD   = 7'd32;

   localparam logic REG_RETRY_LIMIT = 1'b0;

   typedef struct packed {
      logic        start_req;
      logic [1:0]  func;
      logic        ap_sel;
      logic [1:0]  reg_addr;
      logic [31:0] wdata;
      logic        swdio_in;
   } req_payload_type;

   typedef struct packed {
      logic        clock_pulse;
      logic        swdio_out;
      logic        swdio_drive;
      logic        busy_res;
      logic        done_res;
      logic        ok;
      logic [31:0] rdata;
      logic [2:0]  ack_code;
   } rsp_payload_type;

endpackage

// ===== rtl/core/swd_host_transfer_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_host_transfer_engine_core
// Serial wire debug host bit sequencer: one SWCLK period per item while a transfer runs.
// Output: the result of an item is registered in the output register when
// the item is taken. Throughput: one item per cycle while the output is not
// stalled; the single bit step of the phase sequencer is the whole per-item path.
// Reset: synchronous, active high; sequencer idle, line released, retry
// limit 15.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine_core
   import swd_hte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   logic [3:0]            retry_limit_ff;
   logic                  line_out_ff, line_out_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0]           shift_ff, shift_in;
   logic [2:0]            ack_ff, ack_in;
   logic [3:0]            attempt_ff, attempt_in;
   logic [1:0]            func_ff, func_in;
   logic                  ap_ff, ap_in;
   logic [1:0]            addr_ff, addr_in;
   logic                  parity_ff, parity_in;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                  accept;
   logic                  is_idle;
   logic                  phase_drv;
   logic                  rnw;
   logic [7:0]            req_byte;
   logic [CountWidth-1:0] count_inc;
   logic [3:0]            attempt_inc;
   logic                  dio;
   logic                  drv;

   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_RETRY_LIMIT) ? {28'd0, retry_limit_ff} : 32'd0;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign is_idle     = (phase_ff < PH_ONES_A) || (phase_ff > PH_FAIL);
   assign phase_drv   = !(phase_ff == PH_ACK || phase_ff == PH_RDATA || phase_ff == PH_RPAR);
   assign rnw         = (func_ff != FUNC_WRITE);
   assign req_byte    = {1'b1, 1'b0, ap_ff ^ rnw ^ addr_ff[0] ^ addr_ff[1],
                         addr_ff[1], addr_ff[0], rnw, ap_ff, 1'b1};
   assign count_inc   = count_ff + 7'd1;
   assign attempt_inc = attempt_ff + 4'd1;

   always_comb begin
      line_out_in = line_out_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      ack_in      = ack_ff;
      attempt_in  = attempt_ff;
      func_in     = func_ff;
      ap_in       = ap_ff;
      addr_in     = addr_ff;
      parity_in   = parity_ff;
      dio         = 1'b0;
      drv         = 1'b0;
      rsp_payload_in = '0;
      rsp_payload_in.busy_res = 1'b1;

      if (is_idle) begin
         phase_in = PH_IDLE;
         rsp_payload_in.busy_res = 1'b0;
         drv = line_out_ff;
         if (req_payload.start_req && req_payload.func <= FUNC_RESET) begin
            func_in    = req_payload.func;
            ap_in      = (req_payload.func == FUNC_RESET) ? 1'b0 : req_payload.ap_sel;
            addr_in    = (req_payload.func == FUNC_RESET) ? 2'd0 : req_payload.reg_addr;
            shift_in   = (req_payload.func == FUNC_WRITE) ? req_payload.wdata : 32'd0;
            count_in   = '0;
            attempt_in = '0;
            parity_in  = 1'b0;
            phase_in   = (req_payload.func == FUNC_RESET) ? PH_ONES_A : PH_REQ;
            rsp_payload_in.busy_res = 1'b1;
         end
      end else if (phase_drv != line_out_ff) begin
         // turnaround
         rsp_payload_in.clock_pulse = 1'b1;
         line_out_in = phase_drv;
      end else begin
         rsp_payload_in.clock_pulse = 1'b1;
         drv = line_out_ff;
         unique case (phase_ff)
            PH_ONES_A, PH_ONES_B, PH_ZEROS: begin
               dio      = (phase_ff != PH_ZEROS);
               count_in = count_inc;
               if (count_inc >= LEN_LINE) begin
                  count_in = '0;
                  phase_in = (phase_ff == PH_ONES_A) ? PH_SWITCH :
                             (phase_ff == PH_ONES_B) ? PH_ZEROS : PH_REQ;
               end
            end
            PH_SWITCH: begin
               dio      = SWITCH_CODE[count_ff[3:0]];
               count_in = count_inc;
               if (count_inc >= LEN_SWITCH) begin
                  count_in = '0;
                  phase_in = PH_ONES_B;
               end
            end
            PH_REQ: begin
               dio      = req_byte[count_ff[2:0]];
               count_in = count_inc;
               if (count_inc >= LEN_REQ) begin
                  count_in = '0;
                  phase_in = PH_ACK;
               end
            end
            PH_ACK: begin
               ack_in   = {req_payload.swdio_in, ack_ff[2:1]};
               count_in = count_inc;
               if (count_inc >= LEN_ACK) begin
                  count_in  = '0;
                  parity_in = 1'b0;
                  if (ack_in == ACK_OK) begin
                     phase_in = rnw ? PH_RDATA : PH_WDATA;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
            end
            PH_WDATA: begin
               dio       = shift_ff[0];
               parity_in = parity_ff ^ shift_ff[0];
               shift_in  = {1'b0, shift_ff[31:1]};
               count_in  = count_inc;
               if (count_inc >= LEN_WORD) begin
                  count_in = '0;
                  phase_in = PH_WPAR;
               end
            end
            PH_WPAR: begin
               dio      = parity_ff;
               phase_in = PH_WIDLE;
            end
            PH_RDATA: begin
               shift_in  = {req_payload.swdio_in, shift_ff[31:1]};
               parity_in = parity_ff ^ req_payload.swdio_in;
               count_in  = count_inc;
               if (count_inc >= LEN_WORD) begin
                  count_in = '0;
                  phase_in = PH_RPAR;
               end
            end
            PH_RPAR: begin
               phase_in = (req_payload.swdio_in == parity_ff) ? PH_RIDLE : PH_FAIL;
               count_in = '0;
            end
            PH_WIDLE, PH_RIDLE: begin
               rsp_payload_in.done_res = 1'b1;
               rsp_payload_in.ok       = 1'b1;
               rsp_payload_in.rdata    = rnw ? shift_ff : 32'd0;
               phase_in = PH_IDLE;
            end
            default: begin
               // failed attempt: 32 idle zeros then retry or give up
               count_in = count_inc;
               if (count_inc >= LEN_WORD) begin
                  count_in   = '0;
                  attempt_in = attempt_inc;
                  if (attempt_inc >= retry_limit_ff) begin
                     rsp_payload_in.done_res = 1'b1;
                     rsp_payload_in.rdata    = rnw ? shift_ff : 32'd0;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_REQ;
                  end
               end
            end
         endcase
      end

      rsp_payload_in.swdio_drive = drv;
      rsp_payload_in.swdio_out   = drv & dio;
      rsp_payload_in.ack_code    = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_RESET;
         line_out_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         count_ff       <= '0;
         shift_ff       <= '0;
         ack_ff         <= '0;
         attempt_ff     <= '0;
         func_ff        <= FUNC_WRITE;
         ap_ff          <= 1'b0;
         addr_ff        <= '0;
         parity_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (psel && penable && pwrite && paddr[2] == REG_RETRY_LIMIT) begin
            retry_limit_ff <= pwdata[3:0];
         end
         if (accept) begin
            line_out_ff <= line_out_in;
            phase_ff    <= phase_in;
            count_ff    <= count_in;
            shift_ff    <= shift_in;
            ack_ff      <= ack_in;
            attempt_ff  <= attempt_in;
            func_ff     <= func_in;
            ap_ff       <= ap_in;
            addr_ff     <= addr_in;
            parity_ff   <= parity_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule
